// File: rtl/mfb_pkg.sv
// Shared constants, types and byte functions of the Modbus frame builder.
`timescale 1ns / 1ps

package mfb_pkg;

	// Link framing codes
	localparam logic [1:0] MODE_TCP   = 2'd0;
	localparam logic [1:0] MODE_RTU   = 2'd1;
	localparam logic [1:0] MODE_ASCII = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_RTU;

	localparam int unsigned FRAME_MAX = 7;
	localparam int unsigned CNT_W     = $clog2(FRAME_MAX + 1);

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  CHAR_COLON = 8'h3A;  // ':'
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;  // '0'
	localparam logic [7:0]  CHAR_ALPHA = 8'h37;  // 'A' - 10

	// One byte of framed output, with its end-of-message mark
	typedef struct packed {
		logic       last;
		logic [7:0] value;
	} entry_t;

	// All output bytes caused by one input byte, entry 0 goes out first
	typedef struct packed {
		entry_t [FRAME_MAX-1:0] entries;
		logic [CNT_W-1:0]       count;
	} frame_t;

	// Uppercase hex character of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] n;
		n = {4'h0, nib};
		return (nib < 4'd10) ? (CHAR_ZERO + n) : (CHAR_ALPHA + n);
	endfunction

	// CRC-16/MODBUS update by one byte, reflected, eight shift steps
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/mfb_if.sv
// Valid/ready channel interfaces of the Modbus frame builder.
`timescale 1ns / 1ps

// Message bytes in
interface mfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_frame;
	logic       last_of_frame;
	logic [8:0] frame_length;

	modport source (output valid, data_byte, first_of_frame, last_of_frame,
		frame_length, input ready);
	modport sink (input valid, data_byte, first_of_frame, last_of_frame,
		frame_length, output ready);
endinterface

// Framed bytes out
interface mfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, out_byte, out_last, input ready);
	modport sink (input valid, out_byte, out_last, output ready);
endinterface

// Link mode register writes
interface mfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] link_mode;

	modport source (output valid, link_mode, input ready);
	modport sink (input valid, link_mode, output ready);
endinterface

// File: rtl/modbus_frame_builder_top.sv
// Top level of the Modbus outgoing frame builder.
`timescale 1ns / 1ps

// Modbus frame builder. Message bytes (slave address first, then the PDU)
// arrive on src, one per transaction, with first_of_frame/last_of_frame
// marks and the message length on the first byte. The framed byte stream
// leaves on dst, one byte per transaction, out_last set on the final byte
// of a message. link_mode (written over cfg, reset value RTU) picks the
// framing: TCP puts a 6-byte header (incremented transaction id, protocol
// 0, length, big-endian) before the first byte; RTU appends CRC-16/MODBUS
// low byte first; ASCII sends ':', two hex characters per byte and the
// LRC in hex. Mode 3 swallows input bytes with no output. Each input byte
// is framed combinationally into a small output buffer, which then drains
// one byte per cycle while dst is ready; the next input byte is taken in
// the cycle the buffer's last byte leaves, or while the buffer is empty.
// An input byte makes 1 output byte for TCP/RTU data, 7 for a TCP first
// byte, 3 for an RTU last byte, 2 to 5 in ASCII and none in mode 3.
// Change link_mode only while no message bytes are in flight.

module modbus_frame_builder_top (
	input  logic       clk,
	input  logic       arst_n,
	mfb_in_if.sink     src,
	mfb_out_if.source  dst,
	mfb_cfg_if.sink    cfg
);

	logic [1:0]      link_mode_q;
	logic            can_load;
	logic            take;
	logic            load;
	mfb_pkg::frame_t frame;

	// Mode register: writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= mfb_pkg::MODE_RESET;
		end else if (cfg.valid) begin
			link_mode_q <= cfg.link_mode;
		end
	end

	// Input transaction completes when the buffer is free or freeing now
	assign src.ready = can_load;
	assign take      = src.valid && can_load;
	assign load      = take && (frame.count != '0);

	mfb_framer u_framer (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (src.data_byte),
		.first_of_frame (src.first_of_frame),
		.last_of_frame  (src.last_of_frame),
		.frame_length   (src.frame_length),
		.link_mode      (link_mode_q),
		.frame          (frame)
	);

	mfb_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.frame    (frame),
		.can_load (can_load),
		.dst      (dst)
	);

endmodule

// File: rtl/mfb_framer.sv
// Framing logic: CRC, LRC and transaction id state, builds the output bytes of one input byte.
`timescale 1ns / 1ps

module mfb_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                first_of_frame,
	input  logic                last_of_frame,
	input  logic [8:0]          frame_length,
	input  logic [1:0]          link_mode,
	output mfb_pkg::frame_t     frame
);

	logic [15:0] tid_q;
	logic [15:0] crc_q;
	logic [7:0]  lrc_q;

	logic [15:0] tid_next;
	logic [15:0] crc_next;
	logic [7:0]  lrc_next;
	logic [7:0]  lrc_val;
	logic [7:0]  hex_hi;
	logic [7:0]  hex_lo;
	logic [7:0]  lrc_hi;
	logic [7:0]  lrc_lo;
	logic        active;

	assign active   = (link_mode == mfb_pkg::MODE_TCP) || (link_mode == mfb_pkg::MODE_RTU)
		|| (link_mode == mfb_pkg::MODE_ASCII);
	assign crc_next = mfb_pkg::crc_update(first_of_frame ? mfb_pkg::CRC_INIT : crc_q,
		data_byte);
	assign lrc_next = (first_of_frame ? 8'h00 : lrc_q) + data_byte;
	assign lrc_val  = 8'h00 - lrc_next;
	assign tid_next = tid_q + 16'd1;
	assign hex_hi   = mfb_pkg::hex_char(data_byte[7:4]);
	assign hex_lo   = mfb_pkg::hex_char(data_byte[3:0]);
	assign lrc_hi   = mfb_pkg::hex_char(lrc_val[7:4]);
	assign lrc_lo   = mfb_pkg::hex_char(lrc_val[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_q <= '0;
			crc_q <= mfb_pkg::CRC_INIT;
			lrc_q <= '0;
		end else if (take && active) begin
			crc_q <= crc_next;
			lrc_q <= lrc_next;
			if ((link_mode == mfb_pkg::MODE_TCP) && first_of_frame) begin
				tid_q <= tid_next;
			end
		end
	end

	always_comb begin
		frame = '0;
		case (link_mode)
			mfb_pkg::MODE_TCP: begin
				if (first_of_frame) begin
					frame.entries[0].value = tid_next[15:8];
					frame.entries[1].value = tid_next[7:0];
					frame.entries[2].value = 8'h00;
					frame.entries[3].value = 8'h00;
					frame.entries[4].value = {7'h00, frame_length[8]};
					frame.entries[5].value = frame_length[7:0];
					frame.entries[6].value = data_byte;
					frame.entries[6].last  = last_of_frame;
					frame.count = mfb_pkg::CNT_W'(7);
				end else begin
					frame.entries[0].value = data_byte;
					frame.entries[0].last  = last_of_frame;
					frame.count = mfb_pkg::CNT_W'(1);
				end
			end
			mfb_pkg::MODE_RTU: begin
				frame.entries[0].value = data_byte;
				if (last_of_frame) begin
					frame.entries[1].value = crc_next[7:0];
					frame.entries[2].value = crc_next[15:8];
					frame.entries[2].last  = 1'b1;
					frame.count = mfb_pkg::CNT_W'(3);
				end else begin
					frame.count = mfb_pkg::CNT_W'(1);
				end
			end
			mfb_pkg::MODE_ASCII: begin
				if (first_of_frame) begin
					frame.entries[0].value = mfb_pkg::CHAR_COLON;
					frame.entries[1].value = hex_hi;
					frame.entries[2].value = hex_lo;
					frame.entries[3].value = lrc_hi;
					frame.entries[4].value = lrc_lo;
					frame.entries[4].last  = 1'b1;
					frame.count = last_of_frame ? mfb_pkg::CNT_W'(5) : mfb_pkg::CNT_W'(3);
				end else begin
					frame.entries[0].value = hex_hi;
					frame.entries[1].value = hex_lo;
					frame.entries[2].value = lrc_hi;
					frame.entries[3].value = lrc_lo;
					frame.entries[3].last  = 1'b1;
					frame.count = last_of_frame ? mfb_pkg::CNT_W'(4) : mfb_pkg::CNT_W'(2);
				end
			end
			default: begin
				frame = '0;  // unused mode: no output
			end
		endcase
	end

endmodule

// File: rtl/mfb_serializer.sv
// Output buffer: holds the bytes of one input byte and shifts them out one per cycle while dst is ready.
`timescale 1ns / 1ps

module mfb_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mfb_pkg::frame_t  frame,
	output logic             can_load,
	mfb_out_if.source        dst
);

	mfb_pkg::entry_t [mfb_pkg::FRAME_MAX-1:0] ent_q;
	logic [mfb_pkg::CNT_W-1:0]                rem_q;
	logic                                     pop;

	assign dst.valid    = (rem_q != '0);
	assign dst.out_byte = ent_q[0].value;
	assign dst.out_last = ent_q[0].last;
	assign pop          = dst.valid && dst.ready;
	// free now, or the last held byte leaves this cycle
	assign can_load     = (rem_q == '0) || (pop && (rem_q == mfb_pkg::CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= frame.count;
		end else if (pop) begin
			rem_q <= rem_q - mfb_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= frame.entries;
		end else if (pop) begin
			ent_q <= {mfb_pkg::entry_t'('0), ent_q[mfb_pkg::FRAME_MAX-1:1]};
		end
	end

endmodule
